// ===== hdl/cdi_pkg.sv =====
`default_nettype none

package cdi_pkg;

  localparam int CAPACITY = 1024;
  // power of two
  localparam int SLOTS = 2048;

  localparam int KEY_WORDS = 6;
  localparam int WORD_W = 64;
  localparam int KEY_W = KEY_WORDS * WORD_W;
  localparam int KEY_BYTES = KEY_W / 8;
  localparam int BYTE_CNT_W = $clog2(KEY_BYTES);
  localparam int WSEL_W = $clog2(KEY_WORDS);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SLOT_ENT_W = IDX_W + 1;
  localparam int KEY_DEPTH = CAPACITY * KEY_WORDS;
  localparam int KADDR_W = $clog2(KEY_DEPTH);

  localparam int SET_INDEX_W = 10;
  localparam int UNIQ_W = 11;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W = OUT_DATA_W - (SET_INDEX_W + 2 + UNIQ_W);

  localparam logic [WORD_W-1:0] FNV_OFFSET = 64'hcbf29ce484222325;
  // prime = 2^40 + 0x1b3
  localparam int FNV_PRIME_SHIFT = 40;
  localparam logic [8:0] FNV_PRIME_LO = 9'h1b3;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] value;
  } hash_stat_t;

  function automatic logic [WORD_W-1:0] fnv_round(input logic [WORD_W-1:0] h,
                                                  input logic [7:0] b);
    logic [WORD_W-1:0] x;
    logic [WORD_W+8:0] lo;
    x = h ^ {{(WORD_W - 8){1'b0}}, b};
    lo = x * FNV_PRIME_LO;
    return (x << FNV_PRIME_SHIFT) + lo[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cdi_ram.sv =====
`default_nettype none

module cdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cdi_hash.sv =====
`default_nettype none

module cdi_hash (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [cdi_pkg::KEY_W-1:0]  key,
  output cdi_pkg::hash_stat_t             stat
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [cdi_pkg::BYTE_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [cdi_pkg::WORD_W-1:0]       h_r, h_nxt;
  logic [7:0]                       byte_sel;
  logic                             last_byte;

  // byte k of the key sits at bits 8k and up
  assign byte_sel = key[{cnt_r, 3'b000} +: 8];
  assign last_byte = (cnt_r == cdi_pkg::BYTE_CNT_W'(cdi_pkg::KEY_BYTES - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    h_nxt = h_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      h_nxt = cdi_pkg::FNV_OFFSET;
    end else if (busy_r) begin
      h_nxt = cdi_pkg::fnv_round(h_r, byte_sel);
      cnt_nxt = cnt_r + 1'b1;
      if (last_byte) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
  end

  assign stat.done = done_r;
  assign stat.value = h_r;

endmodule

`default_nettype wire

// ===== hdl/coefficient_set_dedup_indexer.sv =====
// Coefficient set deduplication indexer.
// Input beat: six 64-bit key pairs in in_tdata and the last cell flag on in_tlast.
// Each beat is hashed (64-bit FNV-1a over 48 bytes), the slot table is probed
// linearly from the hash, and the full key is compared word by word against
// the key store. A hit returns the stored dense index; a miss stores the key
// and assigns the next index; a miss with the store full reports table_full.
// Output beat: one result per input beat on out_tdata, last_cell echoed on
// out_tlast. One item is worked on at a time; in_tready is high only between
// items. Each item is hashed, then slots are read and checked in turn; every
// occupied slot that holds a different key costs a slot read and a word-by-word
// key compare up to the first differing word. The next beat can be taken in the
// cycle after the result is loaded, unless the item had last_cell set. The 48
// dependent rounds of the single FNV multiply-add unit and the key compare
// set how long an item takes.
// At reset, and after every item with last_cell set, a clearing pass writes
// every slot table entry, one per cycle, before the next beat is accepted;
// the set count is zeroed with it.
// A finished result sits in an output register; the next beat is accepted
// while it waits, and that beat's result waits until the register is taken.
`default_nettype none

module coefficient_set_dedup_indexer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // key_pair_0, key_pair_1, key_pair_2, key_pair_3, key_pair_4, key_pair_5
  input  wire logic [cdi_pkg::KEY_W-1:0]       in_tdata,
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // set_index, is_new, table_full, unique_count, zero pad
  output logic [cdi_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                 out_tlast
);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_HASH     = 9'b000000100,
    S_SLOT_RD  = 9'b000001000,
    S_SLOT_CHK = 9'b000010000,
    S_KEY_RD   = 9'b000100000,
    S_KEY_CHK  = 9'b001000000,
    S_INSERT   = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

  typedef logic [cdi_pkg::KEY_WORDS-1:0][cdi_pkg::WORD_W-1:0] key_t;

  state_t                          state_r, state_nxt;
  key_t                            key_r, key_nxt;
  logic                            last_r, last_nxt;
  logic [cdi_pkg::SLOT_W-1:0]      slot_r, slot_nxt;
  logic [cdi_pkg::SLOT_W-1:0]      probe_r, probe_nxt;
  logic [cdi_pkg::SLOT_W-1:0]      clr_r, clr_nxt;
  logic [cdi_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [cdi_pkg::WSEL_W-1:0]      word_r, word_nxt;
  logic [cdi_pkg::CNT_W-1:0]       set_count_r, set_count_nxt;
  logic [cdi_pkg::IDX_W-1:0]       res_idx_r, res_idx_nxt;
  logic                            res_new_r, res_new_nxt;
  logic                            res_full_r, res_full_nxt;
  logic                            out_tvalid_r;
  logic [cdi_pkg::OUT_DATA_W-1:0]  out_tdata_r;
  logic                            out_tlast_r;

  logic                            out_free, out_load, hash_start;
  cdi_pkg::hash_stat_t             hash_st;

  logic                            slot_en, slot_we;
  logic [cdi_pkg::SLOT_W-1:0]      slot_addr;
  logic [cdi_pkg::SLOT_ENT_W-1:0]  slot_wdata, slot_rdata;
  logic                            key_en, key_we;
  logic [cdi_pkg::KADDR_W-1:0]     key_addr;
  logic [cdi_pkg::WORD_W-1:0]      key_rdata;
  logic [cdi_pkg::IDX_W-1:0]       key_idx;
  logic                            last_word, probe_end, room;

  cdi_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (key_r),
    .stat  (hash_st)
  );

  cdi_ram #(
    .WIDTH (cdi_pkg::SLOT_ENT_W),
    .DEPTH (cdi_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .en    (slot_en),
    .we    (slot_we),
    .addr  (slot_addr),
    .wdata (slot_wdata),
    .rdata (slot_rdata)
  );

  cdi_ram #(
    .WIDTH (cdi_pkg::WORD_W),
    .DEPTH (cdi_pkg::KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .en    (key_en),
    .we    (key_we),
    .addr  (key_addr),
    .wdata (key_r[word_r]),
    .rdata (key_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign out_free = !out_tvalid_r || out_tready;
  assign last_word = (word_r == cdi_pkg::WSEL_W'(cdi_pkg::KEY_WORDS - 1));
  assign probe_end = (probe_r == cdi_pkg::SLOT_W'(cdi_pkg::SLOTS - 1));
  assign room = (set_count_r < cdi_pkg::CNT_W'(cdi_pkg::CAPACITY));
  assign key_idx = (state_r == S_INSERT) ? set_count_r[cdi_pkg::IDX_W-1:0] : idx_r;
  assign key_addr = cdi_pkg::KADDR_W'(key_idx) * cdi_pkg::KADDR_W'(cdi_pkg::KEY_WORDS)
                  + cdi_pkg::KADDR_W'(word_r);

  always_comb begin
    state_nxt = state_r;
    key_nxt = key_r;
    last_nxt = last_r;
    slot_nxt = slot_r;
    probe_nxt = probe_r;
    clr_nxt = clr_r;
    idx_nxt = idx_r;
    word_nxt = word_r;
    set_count_nxt = set_count_r;
    res_idx_nxt = res_idx_r;
    res_new_nxt = res_new_r;
    res_full_nxt = res_full_r;
    hash_start = 1'b0;
    out_load = 1'b0;
    slot_en = 1'b0;
    slot_we = 1'b0;
    slot_addr = slot_r;
    slot_wdata = {1'b1, set_count_r[cdi_pkg::IDX_W-1:0]};
    key_en = 1'b0;
    key_we = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        slot_en = 1'b1;
        slot_we = 1'b1;
        slot_addr = clr_r;
        slot_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == cdi_pkg::SLOT_W'(cdi_pkg::SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          key_nxt = key_t'(in_tdata);
          last_nxt = in_tlast;
          hash_start = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_st.done) begin
          slot_nxt = hash_st.value[cdi_pkg::SLOT_W-1:0];
          probe_nxt = '0;
          state_nxt = S_SLOT_RD;
        end
      end
      S_SLOT_RD: begin
        slot_en = 1'b1;
        state_nxt = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        word_nxt = '0;
        if (!slot_rdata[cdi_pkg::IDX_W]) begin
          if (room) begin
            state_nxt = S_INSERT;
          end else begin
            res_idx_nxt = '0;
            res_new_nxt = 1'b0;
            res_full_nxt = 1'b1;
            state_nxt = S_RESP;
          end
        end else begin
          idx_nxt = slot_rdata[cdi_pkg::IDX_W-1:0];
          state_nxt = S_KEY_RD;
        end
      end
      S_KEY_RD: begin
        key_en = 1'b1;
        state_nxt = S_KEY_CHK;
      end
      S_KEY_CHK: begin
        if (key_rdata != key_r[word_r]) begin
          if (probe_end) begin
            res_idx_nxt = '0;
            res_new_nxt = 1'b0;
            res_full_nxt = 1'b1;
            state_nxt = S_RESP;
          end else begin
            slot_nxt = slot_r + 1'b1;
            probe_nxt = probe_r + 1'b1;
            state_nxt = S_SLOT_RD;
          end
        end else if (last_word) begin
          res_idx_nxt = idx_r;
          res_new_nxt = 1'b0;
          res_full_nxt = 1'b0;
          state_nxt = S_RESP;
        end else begin
          word_nxt = word_r + 1'b1;
          state_nxt = S_KEY_RD;
        end
      end
      S_INSERT: begin
        key_en = 1'b1;
        key_we = 1'b1;
        if (word_r == '0) begin
          slot_en = 1'b1;
          slot_we = 1'b1;
        end
        if (last_word) begin
          res_idx_nxt = set_count_r[cdi_pkg::IDX_W-1:0];
          res_new_nxt = 1'b1;
          res_full_nxt = 1'b0;
          set_count_nxt = set_count_r + 1'b1;
          state_nxt = S_RESP;
        end else begin
          word_nxt = word_r + 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (last_r) begin
            set_count_nxt = '0;
            clr_nxt = '0;
            state_nxt = S_CLEAR;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      set_count_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      set_count_r <= set_count_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    last_r <= last_nxt;
    slot_r <= slot_nxt;
    probe_r <= probe_nxt;
    idx_r <= idx_nxt;
    word_r <= word_nxt;
    res_idx_r <= res_idx_nxt;
    res_new_r <= res_new_nxt;
    res_full_r <= res_full_nxt;
    if (out_load) begin
      out_tdata_r <= {{cdi_pkg::OUT_PAD_W{1'b0}},
                      cdi_pkg::UNIQ_W'(set_count_r),
                      res_full_r,
                      res_new_r,
                      cdi_pkg::SET_INDEX_W'(res_idx_r)};
      out_tlast_r <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tlast = out_tlast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    set_count_r <= cdi_pkg::CNT_W'(cdi_pkg::CAPACITY))
    else $error("set count above capacity");

  a_hash_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    hash_st.done |-> state_r == S_HASH)
    else $error("hash result outside hash wait");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INSERT |-> room)
    else $error("insert with store full");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_free && last_r)
      |=> (state_r == S_CLEAR && clr_r == '0 && set_count_r == '0))
    else $error("last cell did not start a clean clear pass");

endmodule

`default_nettype wire
